>>> hdl/ntoa_pkg.sv
package ntoa_pkg;

    localparam logic [1:0] CMD_DEC   = 2'd0;
    localparam logic [1:0] CMD_HEX   = 2'd1;
    localparam logic [1:0] CMD_BIN   = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_ONE    = 8'h31;
    localparam logic [7:0] ASCII_LETTER = 8'h37;
    localparam logic [7:0] ASCII_X      = 8'h78;
    localparam logic [7:0] ASCII_B      = 8'h62;

    localparam logic [1:0] PLACE_LAST = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] value;
        logic        show_prefix;
    } ntoa_in_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } ntoa_out_t;

    typedef struct packed {
        logic        ge;
        logic [15:0] diff;
    } ntoa_sub_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PFX0,
        ST_PFX1,
        ST_DEC,
        ST_UNITS,
        ST_HEX,
        ST_BIN
    } ntoa_state_t;

    function automatic logic [15:0] place_value(input logic [1:0] sel);
        logic [15:0] p;
        case (sel)
            2'd0:    p = 16'd10000;
            2'd1:    p = 16'd1000;
            2'd2:    p = 16'd100;
            default: p = 16'd10;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'hA) begin
            c = ASCII_ZERO + {4'h0, nib};
        end else begin
            c = ASCII_LETTER + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

>>> hdl/ntoa_sub_unit.sv
module ntoa_sub_unit (
    input  logic [15:0]        rem,
    input  logic [1:0]         place_sel,
    output ntoa_pkg::ntoa_sub_t res
);
    import ntoa_pkg::*;

    logic [16:0] diff_full;

    // Single compare-and-subtract against the selected decimal place.
    always_comb begin
        diff_full = {1'b0, rem} - {1'b0, place_value(place_sel)};
        res.ge    = ~diff_full[16];
        res.diff  = diff_full[15:0];
    end

endmodule

>>> hdl/number_to_ascii_formatter.sv
// Number to ASCII formatter.
// Input channel (s_valid/s_ready/s_data) takes one request holding a format
// command, a 16-bit value and a prefix flag. Output channel (m_valid/m_ready/
// m_data) returns the ASCII characters one per transfer, with last set on the
// final character of the request.
// Decimal requests run one shared compare-and-subtract unit over the places
// 10000, 1000, 100 and 10: each place subtracts while the remainder is not
// below it, counting the digit, then closes the place and prints the digit
// unless it is a leading zero; the units digit follows from the remainder.
// Hex requests give 2 or 4 characters, binary requests 8 or 10, the larger
// count with the prefix. A request is accepted while idle. Each character
// is formed combinationally and registered in the output register.
// Only one request is in work at a time: s_ready is high only while idle.
// A finished character waits in the output register; during a receiver stall
// the sequencer holds at its next character and resumes when the register
// frees up. A new request may be accepted while the last character waits.
// Reset (aresetn low, synchronous) returns to idle and drops any pending
// character.
module number_to_ascii_formatter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ntoa_pkg::ntoa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ntoa_pkg::ntoa_out_t m_data
);
    import ntoa_pkg::*;

    ntoa_state_t state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  byte_reg, byte_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic [3:0]  digit_reg, digit_next;
    logic        started_reg, started_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic        m_valid_reg;
    ntoa_out_t   m_data_reg;

    logic        out_free;
    logic        emit;
    ntoa_out_t   emit_data;
    logic        print;
    ntoa_sub_t   sub;

    ntoa_sub_unit u_sub (
        .rem       (rem_reg),
        .place_sel (pidx_reg),
        .res       (sub)
    );

    assign out_free = ~m_valid_reg | m_ready;
    assign print    = (digit_reg != 4'd0) | started_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.command)
                        CMD_HEX: state_next = s_data.show_prefix ? ST_PFX0 : ST_HEX;
                        CMD_BIN: state_next = s_data.show_prefix ? ST_PFX0 : ST_BIN;
                        default: state_next = ST_DEC;
                    endcase
                end
            end
            ST_PFX0: begin
                if (out_free) begin
                    state_next = ST_PFX1;
                end
            end
            ST_PFX1: begin
                if (out_free) begin
                    state_next = (cmd_reg == CMD_HEX) ? ST_HEX : ST_BIN;
                end
            end
            ST_DEC: begin
                if (!sub.ge && pidx_reg == PLACE_LAST && (out_free || !print)) begin
                    state_next = ST_UNITS;
                end
            end
            ST_UNITS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HEX: begin
                if (out_free && cnt_reg == 3'd1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BIN: begin
                if (out_free && cnt_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready      = 1'b0;
        emit         = 1'b0;
        emit_data    = '0;
        cmd_next     = cmd_reg;
        rem_next     = rem_reg;
        byte_next    = byte_reg;
        pidx_next    = pidx_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next     = s_data.command;
                    rem_next     = s_data.value;
                    byte_next    = s_data.value[7:0];
                    pidx_next    = 2'd0;
                    digit_next   = 4'd0;
                    started_next = 1'b0;
                    cnt_next     = 3'd0;
                end
            end
            ST_PFX0: begin
                emit                = out_free;
                emit_data.character = ASCII_ZERO;
            end
            ST_PFX1: begin
                emit                = out_free;
                emit_data.character = (cmd_reg == CMD_HEX) ? ASCII_X : ASCII_B;
            end
            ST_DEC: begin
                if (sub.ge) begin
                    rem_next   = sub.diff;
                    digit_next = digit_reg + 4'd1;
                end else begin
                    emit                = out_free & print;
                    emit_data.character = ASCII_ZERO + {4'h0, digit_reg};
                    // advance to the next place once the digit is out or suppressed
                    if (out_free || !print) begin
                        started_next = print;
                        digit_next   = 4'd0;
                        pidx_next    = pidx_reg + 2'd1;
                    end
                end
            end
            ST_UNITS: begin
                emit                = out_free;
                emit_data.character = ASCII_ZERO + {4'h0, rem_reg[3:0]};
                emit_data.last      = 1'b1;
            end
            ST_HEX: begin
                emit                = out_free;
                emit_data.character = nibble_char(byte_reg[7:4]);
                emit_data.last      = (cnt_reg == 3'd1);
                if (out_free) begin
                    byte_next = {byte_reg[3:0], 4'h0};
                    cnt_next  = cnt_reg + 3'd1;
                end
            end
            ST_BIN: begin
                emit                = out_free;
                emit_data.character = byte_reg[7] ? ASCII_ONE : ASCII_ZERO;
                emit_data.last      = (cnt_reg == 3'd7);
                if (out_free) begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    cnt_next  = cnt_reg + 3'd1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        rem_reg     <= rem_next;
        byte_reg    <= byte_next;
        pidx_reg    <= pidx_next;
        digit_reg   <= digit_next;
        started_reg <= started_next;
        cnt_reg     <= cnt_next;
        if (emit) begin
            m_data_reg <= emit_data;
        end
    end

endmodule

>>> bench/number_to_ascii_formatter_tb.sv
`timescale 1ns / 100ps

module number_to_ascii_formatter_tb;
    import ntoa_pkg::*;

    typedef struct packed {
        ntoa_in_t    req;
        logic [79:0] text;
    } stim_row_t;

    localparam logic [79:0] NO_TEXT    = 80'd0;
    localparam int          PHASE_REQS = 129;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ntoa_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ntoa_out_t m_data;

    ntoa_out_t char_expect_q [$];
    stim_row_t stim_rows [$];
    ntoa_out_t next_char;
    int        mismatches = 0;
    int        send_idle  = 24;
    int        recv_idle  = 61;

    number_to_ascii_formatter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Expected characters for one request, in print order.
    function automatic void predict_chars(input ntoa_in_t req);
        logic [127:0] glyphs;
        logic [7:0]   txt [10];
        logic [7:0]   b;
        int unsigned  rest;
        int unsigned  place;
        bit           lead;
        int           n;
        glyphs = "0123456789ABCDEF";
        b      = req.value[7:0];
        n      = 0;
        case (req.command)
            CMD_HEX: begin
                if (req.show_prefix) begin
                    txt[0] = "0";
                    txt[1] = "x";
                    n = 2;
                end
                txt[n]     = glyphs[8 * (15 - b[7:4]) +: 8];
                txt[n + 1] = glyphs[8 * (15 - b[3:0]) +: 8];
                n += 2;
            end
            CMD_BIN: begin
                if (req.show_prefix) begin
                    txt[0] = "0";
                    txt[1] = "b";
                    n = 2;
                end
                for (int k = 7; k >= 0; k--) begin
                    txt[n] = b[k] ? "1" : "0";
                    n++;
                end
            end
            default: begin
                // unused command code falls through to decimal
                rest  = req.value;
                place = 10000;
                lead  = 1'b1;
                while (place > 1) begin
                    if (!lead || rest >= place) begin
                        txt[n] = 8'h30 + 8'(rest / place);
                        n++;
                        lead = 1'b0;
                    end
                    rest  = rest % place;
                    place = place / 10;
                end
                txt[n] = 8'h30 + 8'(rest);
                n++;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            char_expect_q.push_back('{character: txt[k], last: (k == n - 1)});
        end
    endfunction

    function automatic ntoa_in_t rand_request();
        ntoa_in_t    r;
        int unsigned p;
        r.command     = 2'($urandom_range(3));
        r.show_prefix = 1'($urandom_range(1));
        case ($urandom_range(9))
            0, 1, 2, 3: r.value = 16'($urandom);
            4:          r.value = 16'($urandom_range(20));
            5: begin
                // straddle a decimal place boundary
                p = 10;
                repeat ($urandom_range(3)) p = p * 10;
                r.value = 16'(p - 1 + $urandom_range(2));
            end
            6:          r.value = 16'($urandom_range(255));
            7:          r.value = 16'hFFFF - 16'($urandom_range(3));
            default:    r.value = 16'($urandom_range(65535, 9990));
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [15:0] val,
                           input logic pfx, input logic [79:0] text);
        stim_row_t row;
        row.req.command     = cmd;
        row.req.value       = val;
        row.req.show_prefix = pfx;
        row.text            = text;
        stim_rows.push_back(row);
    endtask

    // Leaves s_valid high after the handshake; the next call drops it if it idles.
    task automatic send_request(input ntoa_in_t req, input logic [79:0] text);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (text == NO_TEXT) begin
            predict_chars(req);
        end else begin
            // typed text is right-justified: byte 0 is the final character
            for (int k = 9; k >= 0; k--) begin
                if (text[8 * k +: 8] != 8'h00) begin
                    char_expect_q.push_back('{character: text[8 * k +: 8], last: (k == 0)});
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (char_expect_q.size() == 0) begin
                $display("%0t: unexpected character %h last %b", $time,
                         m_data.character, m_data.last);
                mismatches++;
            end else begin
                next_char = char_expect_q.pop_front();
                if (m_data.character !== next_char.character) begin
                    $display("%0t: character expected %h actual %h", $time,
                             next_char.character, m_data.character);
                    mismatches++;
                end
                if (m_data.last !== next_char.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             next_char.last, m_data.last);
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        add_row(CMD_DEC,   16'd0,     1'b0, "0");
        add_row(CMD_DEC,   16'd65535, 1'b0, "65535");
        add_row(CMD_DEC,   16'd9,     1'b0, "9");
        add_row(CMD_DEC,   16'd10,    1'b0, "10");
        add_row(CMD_DEC,   16'd10000, 1'b0, "10000");
        add_row(CMD_DEC,   16'd9999,  1'b0, "9999");
        add_row(CMD_DEC,   16'd100,   1'b1, "100");
        add_row(CMD_SPARE, 16'd12345, 1'b1, "12345");
        add_row(CMD_SPARE, 16'd0,     1'b0, "0");
        add_row(CMD_HEX,   16'h0000,  1'b0, "00");
        add_row(CMD_HEX,   16'h00FF,  1'b1, "0xFF");
        add_row(CMD_HEX,   16'hAB00,  1'b1, "0x00");
        add_row(CMD_HEX,   16'h1234,  1'b0, "34");
        add_row(CMD_HEX,   16'h009A,  1'b0, "9A");
        add_row(CMD_BIN,   16'h0000,  1'b0, "00000000");
        add_row(CMD_BIN,   16'h00FF,  1'b1, "0b11111111");
        add_row(CMD_BIN,   16'hFF00,  1'b0, "00000000");
        add_row(CMD_BIN,   16'h00A5,  1'b1, NO_TEXT);
        add_row(CMD_DEC,   16'd1001,  1'b0, NO_TEXT);
        add_row(CMD_DEC,   16'd40000, 1'b0, NO_TEXT);
        add_row(CMD_DEC,   16'h8000,  1'b1, NO_TEXT);
        add_row(CMD_HEX,   16'h7F5F,  1'b1, NO_TEXT);
        add_row(CMD_BIN,   16'h5A3C,  1'b0, NO_TEXT);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            send_request(stim_rows[i].req, stim_rows[i].text);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 24 : (phase == 1) ? 61 : 0;
            recv_idle = (phase == 0) ? 61 : (phase == 1) ? 24 : 0;
            repeat (PHASE_REQS) send_request(rand_request(), NO_TEXT);
        end
        s_valid <= 1'b0;

        while (char_expect_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
